// File: design/assert_macros.svh
// assertion helpers for the matrix polynomial core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MPE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define MPE_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define MPE_ASSERT(label, prop)
`define MPE_ASSERT_RST(label, prop)
`endif
`endif

// File: design/mpe_pkg.sv
package mpe_pkg;
  localparam int unsigned MaxDim    = 8;
  localparam int unsigned MaxDegree = 15;
  localparam int unsigned DimW      = $clog2(MaxDim);
  localparam int unsigned AddrW     = 2 * DimW;
  localparam int unsigned CoefW     = $clog2(MaxDegree + 1);
  localparam logic signed [31:0] QOne = 32'sd65536;

  typedef enum logic [1:0] {
    FuncLoadMat  = 2'd0,
    FuncLoadCoef = 2'd1,
    FuncEval     = 2'd2,
    FuncNone     = 2'd3
  } func_e;

  localparam logic [0:0] RegDimension = 1'b0;
  localparam logic [0:0] RegDegree    = 1'b1;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         row;
    logic [2:0]         col;
    logic [3:0]         coef_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

  // saturate a 33-bit sum to 32 bits
  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else sat_add = s[31:0];
  endfunction

  // round a full product at bit 16 (ties up), then saturate
  function automatic logic signed [31:0] q_round(logic signed [63:0] p);
    logic signed [63:0] r;
    logic signed [47:0] q;
    r = p + 64'sd32768;
    q = r[63:16];
    if (q > 48'sh0000_7fff_ffff) q_round = 32'sh7fff_ffff;
    else if (q < -48'sh0000_8000_0000) q_round = 32'sh8000_0000;
    else q_round = q[31:0];
  endfunction
endpackage

// File: design/mpe_ram.sv
module mpe_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: design/mpe_mac.sv
// registered multiply, round/saturate and accumulate
module mpe_mac (
  input  logic               clk_i,
  input  logic               clr_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] acc_o
);
  import mpe_pkg::*;
  logic signed [63:0] prod_q;
  logic signed [31:0] acc_q;
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (clr_i) acc_q <= '0;
    else if (en_i) acc_q <= sat_add(acc_q, q_round(prod_q));
  end
  assign acc_o = acc_q;
endmodule

// File: design/matrix_polynomial_eval_core.sv
// matrix polynomial evaluator: p(A) = sum c_i * A^i in signed Q16.16
// input channel (in_valid_i/in_stall_o, in_data_i): a transaction loads one
// matrix element (func 0), one coefficient (func 1) or starts an evaluation
// (func 2); func 3 is dropped
// loads are accepted back to back while the engine is idle
// an evaluation runs the power loop on one shared mac: it first sets P to the
// identity and clears the sum, then for each power i > 0 every element of P*A
// is built by memory read, multiply, accumulate and write, then P*A is copied
// into P, and every power adds c_i*P to the sum;
// all of this work is serialized on the single mac and one read port on each
// of the power, matrix and sum memories
// the result leaves as n*n transactions in row-major order on out_valid_o /
// out_stall_i, last set on the final element
// while out_valid_o and out_stall_i are high the output register holds and no item is taken
// reset (rst_ni low) sets dimension to 1, degree to 0 and idles the engine;
// memories are not cleared
// config: apb, dimension at byte 0, degree at byte 4
module matrix_polynomial_eval_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpe_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mpe_pkg::out_item_t  out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mpe_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StInit, StMulRd, StMulWait, StMulAcc, StMulWr, StCopyRd, StCopyWr,
    StSumRd, StSumMul, StSumAcc, StSumWr, StOutRd, StOutHold
  } state_e;

  state_e state_q;
  logic [3:0] dim_q, deg_q;
  logic [DimW-1:0] r_q, c_q, k_q, nm1_q;
  logic [CoefW-1:0] i_q, dmax_q;
  logic [2:0] wait_q;
  logic signed [31:0] coef_q;
  out_item_t out_q;
  logic out_valid_q;

  // config port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      RegDimension: prdata = {28'd0, dim_q};
      RegDegree:    prdata = {28'd0, deg_q};
      default:      prdata = '0;
    endcase
  end
  wire cfg_wr = psel & penable & pwrite;

  wire in_acc = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  // memories
  logic mat_we, pw_we, pr_we, sm_we, cf_we;
  logic [AddrW-1:0] mat_ra, mat_wa, pw_ra, pw_wa, pr_ra, pr_wa, sm_ra, sm_wa;
  logic [31:0] mat_rd, pw_rd, pr_rd, sm_rd, cf_rd, pw_wd, pr_wd, sm_wd;
  logic [CoefW-1:0] cf_ra;

  mpe_ram #(.Depth(MaxDim*MaxDim), .Width(32)) u_mat (.clk_i, .we_i(mat_we),
    .waddr_i(mat_wa), .wdata_i(in_data_i.value), .raddr_i(mat_ra), .rdata_o(mat_rd));
  mpe_ram #(.Depth(MaxDim*MaxDim), .Width(32)) u_pw (.clk_i, .we_i(pw_we),
    .waddr_i(pw_wa), .wdata_i(pw_wd), .raddr_i(pw_ra), .rdata_o(pw_rd));
  mpe_ram #(.Depth(MaxDim*MaxDim), .Width(32)) u_pr (.clk_i, .we_i(pr_we),
    .waddr_i(pr_wa), .wdata_i(pr_wd), .raddr_i(pr_ra), .rdata_o(pr_rd));
  mpe_ram #(.Depth(MaxDim*MaxDim), .Width(32)) u_sm (.clk_i, .we_i(sm_we),
    .waddr_i(sm_wa), .wdata_i(sm_wd), .raddr_i(sm_ra), .rdata_o(sm_rd));
  mpe_ram #(.Depth(MaxDegree+1), .Width(32)) u_cf (.clk_i, .we_i(cf_we),
    .waddr_i(in_data_i.coef_index[CoefW-1:0]), .wdata_i(in_data_i.value),
    .raddr_i(cf_ra), .rdata_o(cf_rd));

  // mac operands
  logic mac_clr, mac_en;
  logic signed [31:0] mac_a, mac_b, acc;
  mpe_mac u_mac (.clk_i, .clr_i(mac_clr), .en_i(mac_en), .a_i(mac_a), .b_i(mac_b),
    .acc_o(acc));

  always_comb begin
    mat_we = in_acc && in_data_i.func == FuncLoadMat;
    mat_wa = {in_data_i.row[DimW-1:0], in_data_i.col[DimW-1:0]};
    cf_we  = in_acc && in_data_i.func == FuncLoadCoef;
    mat_ra = {k_q, c_q};
    pw_ra  = {r_q, k_q};
    pr_ra  = {r_q, c_q};
    sm_ra  = {r_q, c_q};
    cf_ra  = i_q;
    pw_we = 1'b0; pw_wa = {r_q, c_q}; pw_wd = pr_rd;
    pr_we = 1'b0; pr_wa = {r_q, c_q}; pr_wd = acc;
    sm_we = 1'b0; sm_wa = {r_q, c_q}; sm_wd = '0;
    mac_clr = 1'b0; mac_en = 1'b0; mac_a = pw_rd; mac_b = mat_rd;
    unique case (state_q)
      StInit: begin
        pw_we = 1'b1; sm_we = 1'b1;
        pw_wd = (r_q == c_q) ? QOne : '0;
      end
      // product for term k passes the memory read and product registers before accumulation
      StMulRd: begin
        mac_clr = (k_q == '0);
        mac_en  = (k_q > DimW'(1));
      end
      StMulWait: mac_en = (wait_q != 3'd0) || (nm1_q != '0);
      StMulAcc:  mac_en = 1'b0;
      StMulWr:   pr_we = 1'b1;
      StCopyWr:  pw_we = 1'b1;
      StSumRd:   pw_ra = {r_q, c_q};
      StSumMul: begin
        mac_clr = 1'b1; mac_a = pw_rd; mac_b = coef_q;
      end
      StSumAcc: begin
        mac_en = 1'b1;
      end
      StSumWr: begin
        sm_we = 1'b1; sm_wd = sat_add(sm_rd, acc);
      end
      default: ;
    endcase
  end

  // sequencer; multiply: read(k), product reg, accumulate: pipelined per k
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; dim_q <= 4'd1; deg_q <= '0;
      r_q <= '0; c_q <= '0; k_q <= '0; i_q <= '0; nm1_q <= '0; dmax_q <= '0;
      wait_q <= '0; out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == RegDimension) dim_q <= pwdata[3:0];
        else deg_q <= pwdata[3:0];
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_acc && in_data_i.func == FuncEval) begin
          nm1_q <= (dim_q == 4'd0) ? '0 :
                   (dim_q > 4'(MaxDim)) ? DimW'(MaxDim - 1) : DimW'(dim_q - 4'd1);
          dmax_q <= (deg_q > 4'(MaxDegree)) ? CoefW'(MaxDegree) : CoefW'(deg_q);
          r_q <= '0; c_q <= '0; k_q <= '0; i_q <= '0;
          state_q <= StInit;
        end
        StInit: begin
          if (c_q != nm1_q) c_q <= c_q + 1'b1;
          else begin
            c_q <= '0;
            if (r_q != nm1_q) r_q <= r_q + 1'b1;
            else begin r_q <= '0; state_q <= StSumRd; end
          end
        end
        StMulRd: begin
          // stream k through read -> product -> accumulate
          if (k_q != nm1_q) k_q <= k_q + 1'b1;
          else begin wait_q <= 3'd0; state_q <= StMulWait; end
        end
        StMulWait: begin
          wait_q <= wait_q + 3'd1;
          if (wait_q == 3'd1) state_q <= StMulAcc;
        end
        StMulAcc: state_q <= StMulWr;
        StMulWr: begin
          k_q <= '0;
          state_q <= StMulRd;
          if (c_q != nm1_q) c_q <= c_q + 1'b1;
          else begin
            c_q <= '0;
            if (r_q != nm1_q) r_q <= r_q + 1'b1;
            else begin r_q <= '0; state_q <= StCopyRd; end
          end
        end
        StCopyRd: state_q <= StCopyWr;
        StCopyWr: begin
          state_q <= StCopyRd;
          if (c_q != nm1_q) c_q <= c_q + 1'b1;
          else begin
            c_q <= '0;
            if (r_q != nm1_q) r_q <= r_q + 1'b1;
            else begin r_q <= '0; state_q <= StSumRd; end
          end
        end
        StSumRd: state_q <= StSumMul;
        StSumMul: state_q <= StSumAcc;
        StSumAcc: state_q <= StSumWr;
        StSumWr: begin
          state_q <= StSumRd;
          if (c_q != nm1_q) c_q <= c_q + 1'b1;
          else begin
            c_q <= '0;
            if (r_q != nm1_q) r_q <= r_q + 1'b1;
            else begin
              r_q <= '0;
              if (i_q == dmax_q) state_q <= StOutRd;
              else begin i_q <= i_q + 1'b1; k_q <= '0; state_q <= StMulRd; end
            end
          end
        end
        StOutRd: if (!out_valid_q || !out_stall_i) state_q <= StOutHold;
        StOutHold: begin
          out_valid_q <= 1'b1;
          out_q.out_row <= 3'(r_q); out_q.out_col <= 3'(c_q);
          out_q.out_value <= sm_rd;
          out_q.last <= (r_q == nm1_q) && (c_q == nm1_q);
          state_q <= StOutRd;
          if (c_q != nm1_q) c_q <= c_q + 1'b1;
          else begin
            c_q <= '0;
            if (r_q != nm1_q) r_q <= r_q + 1'b1;
            else begin r_q <= '0; state_q <= StIdle; end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // coefficient for this power, taken from the registered coefficient memory read
  always_ff @(posedge clk_i) begin
    if (state_q == StSumRd) coef_q <= cf_rd;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "assert_macros.svh"
  `MPE_ASSERT(a_busy_stalls, (state_q != StIdle) |-> in_stall_o)
  `MPE_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> $stable(out_data_o))
  `MPE_ASSERT(a_last_idle, $rose(out_valid_o) && out_data_o.last |-> state_q == StIdle)
  `MPE_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == StIdle) || rst_ni)
endmodule
